/* hdl/hdlc_frame_builder_stuffing_defines.svh */
// assertion macros for the frame builder checker
`ifndef HDLC_FRAME_BUILDER_STUFFING_DEFINES_SVH
`define HDLC_FRAME_BUILDER_STUFFING_DEFINES_SVH

// checked only out of reset
`define HFB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("hfb check failed");

// checked on every edge, reset included
`define HFB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("hfb check failed");

`endif

/* hdl/hfb_pkg.sv */
// types, constants and helpers for the hdlc frame builder
package hfb_pkg;

  localparam logic [7:0] FRAME_FLAG = 8'h7E;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] ESC_FLAG   = 8'h5E;
  localparam logic [7:0] ESC_ESC    = 8'h5D;
  localparam logic [7:0] CTRL_SEQ0  = 8'h00;
  localparam logic [7:0] CTRL_SEQ1  = 8'h40;
  localparam logic [7:0] ADDR_RESET = 8'h03;

  localparam int RUN_MAX = 9;
  localparam int IDX_W   = $clog2(RUN_MAX + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       seq_bit;
    logic       first;
    logic       last;
    logic       empty_frame;
  } item_t;

  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [IDX_W-1:0]        cnt;
    logic                    fend;
  } run_t;

  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } stuff_t;

  function automatic stuff_t stuff(input logic [7:0] b);
    stuff_t s;
    s.two = 1'b0;
    s.b0  = b;
    s.b1  = 8'h00;
    if (b == FRAME_FLAG) begin
      s.two = 1'b1;
      s.b0  = ESC_BYTE;
      s.b1  = ESC_FLAG;
    end else if (b == ESC_BYTE) begin
      s.two = 1'b1;
      s.b0  = ESC_BYTE;
      s.b1  = ESC_ESC;
    end
    return s;
  endfunction

endpackage

/* hdl/hfb_expand.sv */
// expands one request into its full list of line bytes and the next check value
module hfb_expand (
  input  hfb_pkg::item_t    item,
  input  logic [7:0]        address_byte,
  input  logic [7:0]        acc,
  output hfb_pkg::run_t     run,
  output logic [7:0]        acc_nxt
);

  logic                     hdr;
  logic [7:0]               ctrl;
  logic [7:0]               acc_x;
  hfb_pkg::stuff_t          sd;
  hfb_pkg::stuff_t          sb;
  logic [hfb_pkg::IDX_W-1:0] p_data;
  logic [hfb_pkg::IDX_W-1:0] p_bcc;
  logic [hfb_pkg::IDX_W-1:0] p_flag;

  always_comb begin
    hdr    = item.empty_frame | item.first;
    ctrl   = item.seq_bit ? hfb_pkg::CTRL_SEQ1 : hfb_pkg::CTRL_SEQ0;
    acc_x  = (item.first ? 8'h00 : acc) ^ item.data_byte;
    sd     = hfb_pkg::stuff(item.data_byte);
    sb     = hfb_pkg::stuff(acc_x);
    p_data = hdr ? hfb_pkg::IDX_W'(4) : '0;
    p_bcc  = p_data + (sd.two ? hfb_pkg::IDX_W'(2) : hfb_pkg::IDX_W'(1));
    p_flag = p_bcc;
    run.bytes = '0;
    run.cnt   = '0;
    run.fend  = 1'b0;
    acc_nxt   = acc_x;
    if (hdr) begin
      run.bytes[0] = hfb_pkg::FRAME_FLAG;
      run.bytes[1] = address_byte;
      run.bytes[2] = ctrl;
      run.bytes[3] = address_byte ^ ctrl;
    end
    if (item.empty_frame) begin
      run.bytes[4] = 8'h00;
      run.bytes[5] = hfb_pkg::FRAME_FLAG;
      run.cnt      = hfb_pkg::IDX_W'(6);
      run.fend     = 1'b1;
      acc_nxt      = 8'h00;
    end else begin
      run.bytes[p_data] = sd.b0;
      if (sd.two) begin
        run.bytes[p_data + hfb_pkg::IDX_W'(1)] = sd.b1;
      end
      run.cnt = p_bcc;
      if (item.last) begin
        run.bytes[p_bcc] = sb.b0;
        if (sb.two) begin
          run.bytes[p_bcc + hfb_pkg::IDX_W'(1)] = sb.b1;
        end
        p_flag = p_bcc + (sb.two ? hfb_pkg::IDX_W'(2) : hfb_pkg::IDX_W'(1));
        run.bytes[p_flag] = hfb_pkg::FRAME_FLAG;
        run.cnt  = p_flag + hfb_pkg::IDX_W'(1);
        run.fend = 1'b1;
        acc_nxt  = 8'h00;
      end
    end
  end

endmodule

/* hdl/hfb_emit.sv */
// holds one expanded request and sends its bytes one per cycle through the output register while out_stall is low
module hfb_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  hfb_pkg::run_t  run_in,
  output logic           take,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_run_last,
  output logic           out_frame_end
);

  hfb_pkg::run_t             run_r;
  logic                      run_valid_r;
  logic [hfb_pkg::IDX_W-1:0] idx_r;
  logic                      out_valid_r;
  logic [7:0]                out_byte_r;
  logic                      out_run_last_r;
  logic                      out_frame_end_r;
  logic                      load_out;
  logic                      at_end;

  assign at_end   = idx_r == (run_r.cnt - hfb_pkg::IDX_W'(1));
  assign load_out = run_valid_r & (~out_valid_r | ~out_stall);
  assign take     = ~run_valid_r | (load_out & at_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      run_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (load_out) begin
      if (at_end) begin
        run_valid_r <= 1'b0;
      end
      idx_r <= idx_r + hfb_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_r <= run_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_byte_r      <= run_r.bytes[idx_r];
      out_run_last_r  <= at_end;
      out_frame_end_r <= at_end & run_r.fend;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_run_last  = out_run_last_r;
  assign out_frame_end = out_frame_end_r;

endmodule

/* hdl/hdlc_frame_builder_stuffing.sv */
// top level of the hdlc information frame builder with byte stuffing
//
// input channel: one payload byte per request with first, last, seq_bit and
// empty_frame marks; accepted when in_valid is high and in_stall is low
// output channel: one line byte per transfer, out_run_last on the final byte
// of a request, out_frame_end on the closing flag
// config channel: cfg_data sets the address byte; cfg_ready is always high,
// write only while no request is in flight
// first byte path: an accepted request is held in the byte sender's run register,
// then its first byte moves into the output register once that register can take it
// throughput: a request producing k bytes (1 to 9) occupies the byte sender
// until all k have moved out, so a stream runs at one line byte per cycle while
// out_stall is low; the next request is taken in the cycle its predecessor's last
// byte moves to the output register
// reset: address byte returns to 0x03, check value to zero, both channels empty
// when out_stall is high the output register holds its byte and in_stall
// stays high while a held request still has bytes that cannot move
module hdlc_frame_builder_stuffing (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_seq_bit,
  input  logic       in_first,
  input  logic       in_last,
  input  logic       in_empty_frame,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_frame_end,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0]     address_r;
  logic [7:0]     acc_r;
  logic [7:0]     acc_nxt;
  hfb_pkg::item_t item;
  hfb_pkg::run_t  run;
  logic           take;
  logic           accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = ~take;
  assign accept    = in_valid & take;

  assign item.data_byte   = in_data_byte;
  assign item.seq_bit     = in_seq_bit;
  assign item.first       = in_first;
  assign item.last        = in_last;
  assign item.empty_frame = in_empty_frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      address_r <= hfb_pkg::ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      address_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 8'h00;
    end else if (accept) begin
      acc_r <= acc_nxt;
    end
  end

  hfb_expand u_expand (
    .item         (item),
    .address_byte (address_r),
    .acc          (acc_r),
    .run          (run),
    .acc_nxt      (acc_nxt)
  );

  hfb_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (accept),
    .run_in        (run),
    .take          (take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end)
  );

endmodule

/* hdl/hfb_checker.sv */
// port level checks for the hdlc frame builder and their binding
`include "hdlc_frame_builder_stuffing_defines.svh"

module hfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_frame_end
);

  // output empty right after reset
  `HFB_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

  // closing flag ends the request's bytes
  `HFB_ASSERT(a_frame_end_flag, out_valid && out_frame_end |-> out_byte == hfb_pkg::FRAME_FLAG && out_run_last)

  // a request's bytes leave without gaps
  `HFB_ASSERT(a_run_no_gap, out_valid && !out_stall && !out_run_last |=> out_valid)

  // stalled byte holds
  `HFB_ASSERT(a_stall_hold, out_valid && out_stall |=> out_valid && $stable(out_byte))

endmodule

bind hdlc_frame_builder_stuffing hfb_checker u_hfb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_byte      (out_byte),
  .out_run_last  (out_run_last),
  .out_frame_end (out_frame_end)
);

/* verif/tb_hdlc_frame_builder_stuffing.sv */
// testbench for the hdlc frame builder: queued requests, line byte prediction, scoreboard
`timescale 1ns / 1ps

module tb_hdlc_frame_builder_stuffing;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } line_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_seq_bit = 1'b0;
  logic       in_first = 1'b0;
  logic       in_last = 1'b0;
  logic       in_empty_frame = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_frame_end;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  hfb_pkg::item_t pending_requests[$];
  line_byte_t     run_buf[$];
  line_byte_t     expected_bytes[$];
  logic [7:0]     addr_shadow = hfb_pkg::ADDR_RESET;
  logic [7:0]     frame_bcc = 8'h00;
  int             snd_idle_pct = 0;
  int             rcv_stall_pct = 0;
  int             mismatch_count = 0;
  int             quiet_cycles = 0;

  hdlc_frame_builder_stuffing dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_seq_bit     (in_seq_bit),
    .in_first       (in_first),
    .in_last        (in_last),
    .in_empty_frame (in_empty_frame),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_frame_end  (out_frame_end),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic push_raw(input logic [7:0] b, input logic fend);
    line_byte_t e;
    e.out_byte  = b;
    e.run_last  = 1'b0;
    e.frame_end = fend;
    run_buf.push_back(e);
  endtask

  task automatic push_escaped(input logic [7:0] b);
    if (b == hfb_pkg::FRAME_FLAG) begin
      push_raw(hfb_pkg::ESC_BYTE, 1'b0);
      push_raw(hfb_pkg::ESC_FLAG, 1'b0);
    end else if (b == hfb_pkg::ESC_BYTE) begin
      push_raw(hfb_pkg::ESC_BYTE, 1'b0);
      push_raw(hfb_pkg::ESC_ESC, 1'b0);
    end else begin
      push_raw(b, 1'b0);
    end
  endtask

  task automatic predict_line_bytes(input logic [7:0] d, input logic seq, input logic first,
                                    input logic last, input logic empty);
    logic [7:0] ctrl;
    line_byte_t e;
    ctrl = seq ? hfb_pkg::CTRL_SEQ1 : hfb_pkg::CTRL_SEQ0;
    run_buf.delete();
    if (empty || first) begin
      frame_bcc = 8'h00;
      push_raw(hfb_pkg::FRAME_FLAG, 1'b0);
      push_raw(addr_shadow, 1'b0);
      push_raw(ctrl, 1'b0);
      push_raw(addr_shadow ^ ctrl, 1'b0);
    end
    if (empty) begin
      push_raw(8'h00, 1'b0);
    end else begin
      frame_bcc = frame_bcc ^ d;
      push_escaped(d);
      if (last) push_escaped(frame_bcc);
    end
    if (empty || last) begin
      push_raw(hfb_pkg::FRAME_FLAG, 1'b1);
      frame_bcc = 8'h00;
    end
    foreach (run_buf[i]) begin
      e = run_buf[i];
      e.run_last = (i == run_buf.size() - 1);
      expected_bytes.push_back(e);
    end
  endtask

  task automatic queue_item(input logic [7:0] d, input logic seq, input logic first,
                            input logic last, input logic empty);
    hfb_pkg::item_t it;
    it.data_byte   = d;
    it.seq_bit     = seq;
    it.first       = first;
    it.last        = last;
    it.empty_frame = empty;
    pending_requests.push_back(it);
  endtask

  function automatic logic [7:0] pick_payload();
    int r;
    r = $urandom_range(7);
    if (r == 0) return hfb_pkg::FRAME_FLAG;
    if (r == 1) return hfb_pkg::ESC_BYTE;
    return 8'($urandom_range(255));
  endfunction

  task automatic write_address(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    addr_shadow = v;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_bytes.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin : drive_requests
    hfb_pkg::item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        predict_line_bytes(in_data_byte, in_seq_bit, in_first, in_last, in_empty_frame);
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          nxt = pending_requests.pop_front();
          in_valid       <= 1'b1;
          in_data_byte   <= nxt.data_byte;
          in_seq_bit     <= nxt.seq_bit;
          in_first       <= nxt.first;
          in_last        <= nxt.last;
          in_empty_frame <= nxt.empty_frame;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check_line_bytes
    line_byte_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected byte %02h run_last %b frame_end %b",
                     out_byte, out_run_last, out_frame_end);
        end else begin
          e = expected_bytes.pop_front();
          if (out_byte !== e.out_byte || out_run_last !== e.run_last ||
              out_frame_end !== e.frame_end) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("mismatch: expected byte %02h run_last %b frame_end %b, got %02h %b %b",
                       e.out_byte, e.run_last, e.frame_end,
                       out_byte, out_run_last, out_frame_end);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    do @(posedge clk); while (quiet_cycles < WATCHDOG_LIMIT);
    $display("watchdog expired after %0d quiet cycles", quiet_cycles);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] phase_addr[4];
    int         sender_pct[4];
    int         receiver_pct[4];
    int         n;
    int         len;
    logic       seq;
    phase_addr   = '{8'h00, 8'hFF, hfb_pkg::FRAME_FLAG, 8'h00};
    phase_addr[3] = 8'($urandom_range(255));
    sender_pct   = '{0, 64, 0, 33};
    receiver_pct = '{0, 0, 64, 33};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests under the reset address
    queue_item(8'hAA, 1'b0, 1'b0, 1'b0, 1'b1);
    queue_item(hfb_pkg::FRAME_FLAG, 1'b1, 1'b1, 1'b1, 1'b1);
    queue_item(hfb_pkg::FRAME_FLAG, 1'b1, 1'b1, 1'b0, 1'b0);
    queue_item(hfb_pkg::ESC_BYTE, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(8'hFF, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_item(hfb_pkg::ESC_FLAG, 1'b0, 1'b0, 1'b1, 1'b0);
    queue_item(hfb_pkg::ESC_BYTE, 1'b0, 1'b1, 1'b1, 1'b0);
    queue_item(hfb_pkg::FRAME_FLAG, 1'b1, 1'b1, 1'b1, 1'b0);
    queue_item(8'h12, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_item(8'h6C, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
    queue_item(8'h33, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(8'h44, 1'b1, 1'b0, 1'b1, 1'b0);
    queue_item(8'h01, 1'b1, 1'b1, 1'b0, 1'b0);
    queue_item(8'h02, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_item(8'h5D, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(8'h03, 1'b0, 1'b0, 1'b1, 1'b0);
    queue_item(8'h80, 1'b0, 1'b0, 1'b0, 1'b1);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      write_address(phase_addr[p]);
      snd_idle_pct  = sender_pct[p];
      rcv_stall_pct = receiver_pct[p];
      n = 0;
      while (n < 75) begin
        if ($urandom_range(99) < 15) begin
          queue_item(8'($urandom_range(255)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
          n++;
        end else begin
          len = $urandom_range(6);
          seq = 1'($urandom_range(1));
          if (len == 0) begin
            queue_item(8'($urandom_range(255)), seq, 1'($urandom_range(1)),
                       1'($urandom_range(1)), 1'b1);
            n++;
          end else begin
            for (int k = 0; k < len; k++)
              queue_item(pick_payload(), seq, k == 0, k == len - 1, 1'b0);
            n += len;
          end
        end
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      mismatch_count++;
      $display("%0d expected bytes never arrived", expected_bytes.size());
    end
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/hfb_pkg.sv
hdl/hfb_expand.sv
hdl/hfb_emit.sv
hdl/hdlc_frame_builder_stuffing.sv
hdl/hfb_checker.sv
verif/tb_hdlc_frame_builder_stuffing.sv
